// ===== sv/sorted_key_set_unit_macros.svh =====
// Assertion macros for the sorted key set unit.
// Used by sorted_key_set_unit.sv; no other dependencies.
`ifndef SORTED_KEY_SET_UNIT_MACROS_SVH
`define SORTED_KEY_SET_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SKS_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) cond) else $error(msg);
`define SKS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define SKS_CHECK(label, cond, msg)
`define SKS_CHECK_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/sks_pkg.sv =====
// Shared types and constants for the sorted key set unit.
// No dependencies.
package sks_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 7;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 found;
    logic [OUT_CNT_W-1:0] entry_count;
  } result_t;

  typedef struct packed {
    logic cmp;
    logic grow;
    logic shrink;
  } cell_ctrl_t;

endpackage

// ===== sv/sks_cell.sv =====
// One slot of the sorted key chain: holds a key and its valid bit,
// compares against a request key and shifts with its neighbors. Uses sks_pkg.
module sks_cell
  import sks_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [KEY_W-1:0] cmp_key,
  input  logic [KEY_W-1:0] new_key,
  input  logic [KEY_W-1:0] left_key,
  input  logic             left_lt,
  input  logic             left_valid,
  input  logic [KEY_W-1:0] right_key,
  input  logic             right_valid,
  output logic [KEY_W-1:0] key_out,
  output logic             valid,
  output logic             lt,
  output logic             eq
);

  logic [KEY_W-1:0] stored;

  assign key_out = stored;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      if (ctrl.cmp) begin
        lt <= valid && (stored < cmp_key);
        eq <= valid && (stored == cmp_key);
      end
      if (ctrl.grow) begin
        valid <= left_valid;
      end else if (ctrl.shrink) begin
        valid <= right_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.grow && !lt) begin
      stored <= left_lt ? new_key : left_key;
    end else if (ctrl.shrink && !lt) begin
      stored <= right_key;
    end
  end

endmodule

// ===== sv/sorted_key_set_unit.sv =====
// Sorted key set: a chain of CAPACITY key cells kept in ascending order.
// The result strobe (done) is registered from the exec phase that follows the request.
// Requests are taken only while idle (busy low): the compare phase compares in every cell,
// then the exec phase inserts or closes the gap in all cells at once. Results cannot stall.
// Reset empties the set (count and valid bits); stored keys are not cleared.
// Depends on sks_pkg, sks_cell and sorted_key_set_unit_macros.svh.
module sorted_key_set_unit
  import sks_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

`include "sorted_key_set_unit_macros.svh"

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_EXEC = 1'b1;

  logic             phase;
  logic [1:0]       req_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic [KEY_W-1:0]    key_vec [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;

  cell_ctrl_t ctrl;
  logic       present;
  logic       full;
  logic [1:0] status;
  logic [CNT_W+OUT_CNT_W-1:0] count_ext;

  assign busy    = (phase == PH_EXEC);
  assign present = |eq_vec;
  assign full    = valid_vec[CAPACITY-1];

  always_comb begin
    ctrl.cmp    = start && !busy;
    ctrl.grow   = 1'b0;
    ctrl.shrink = 1'b0;
    status      = ST_DONE;
    unique case (req_q)
      REQ_ADD: begin
        if (present) begin
          status = ST_MISS;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.grow = busy;
        end
      end
      REQ_REMOVE: begin
        if (present) begin
          ctrl.shrink = busy;
        end else begin
          status = ST_MISS;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
    count_next = count;
    if (ctrl.grow) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.shrink) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign count_ext = {{OUT_CNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      phase <= ctrl.cmp ? PH_EXEC : PH_IDLE;
      count <= count_next;
      done  <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      req_q <= request.req_type;
      key_q <= request.key;
    end
    if (busy) begin
      result.status      <= status;
      result.found       <= present;
      result.entry_count <= count_ext[OUT_CNT_W-1:0];
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] left_key;
    logic             left_lt;
    logic             left_valid;
    logic [KEY_W-1:0] right_key;
    logic             right_valid;

    if (i == 0) begin : g_first
      assign left_key   = key_q;
      assign left_lt    = 1'b1;
      assign left_valid = 1'b1;
    end else begin : g_mid
      assign left_key   = key_vec[i-1];
      assign left_lt    = lt_vec[i-1];
      assign left_valid = valid_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key   = key_vec[i];
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_key   = key_vec[i+1];
      assign right_valid = valid_vec[i+1];
    end

    sks_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .cmp_key     (request.key),
      .new_key     (key_q),
      .left_key    (left_key),
      .left_lt     (left_lt),
      .left_valid  (left_valid),
      .right_key   (right_key),
      .right_valid (right_valid),
      .key_out     (key_vec[i]),
      .valid       (valid_vec[i]),
      .lt          (lt_vec[i]),
      .eq          (eq_vec[i])
    );
  end

  `SKS_CHECK(a_count_matches_valid, $countones(valid_vec) == count, "count disagrees with cells")
  `SKS_CHECK(a_valid_prefix, ((valid_vec >> 1) & ~valid_vec) == '0, "valid cells not contiguous")
  `SKS_CHECK(a_lt_prefix, !busy || (((lt_vec >> 1) & ~lt_vec) == '0), "keys out of order")
  `SKS_CHECK(a_eq_single, !busy || $onehot0(eq_vec), "duplicate key held")
  `SKS_CHECK_NEXT(a_exec_one_cycle, busy, !busy && done, "exec phase overran")

endmodule
